// ===== rtl/gbf_pkg.sv =====
package gbf_pkg;

  // Default coordinate width and fixed field widths.
  localparam int COORD_BITS_DEF = 12;
  localparam int STRIDE_BITS    = 16;
  localparam int ADDR_BITS      = 28;
  localparam int PIX_BITS       = 32;
  localparam int CH_BITS        = 8;

  // Blend constants.
  localparam logic [CH_BITS-1:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [CH_BITS-1:0] COV_FULL     = 8'hff;
  localparam logic [CH_BITS-1:0] COV_NONE     = 8'h00;
  localparam logic [15:0]        ROUND_BIAS   = 16'h0080;

  // Function codes carried in tuser.
  localparam logic FUNC_FILL  = 1'b0;
  localparam logic FUNC_BLEND = 1'b1;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_FB_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FB_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FB_STRIDE = 2'd2;

  // Load enables for the three pipeline registers.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } gbf_adv_t;

endpackage

// ===== rtl/gbf_regs.sv =====
module gbf_regs
  import gbf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic [COORD_BITS:0]    fb_width,
  output logic [COORD_BITS:0]    fb_height,
  output logic [STRIDE_BITS-1:0] fb_stride
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= '0;
      fb_height <= '0;
      fb_stride <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_FB_WIDTH:  fb_width  <= pwdata[COORD_BITS:0];
        REG_FB_HEIGHT: fb_height <= pwdata[COORD_BITS:0];
        REG_FB_STRIDE: fb_stride <= pwdata[STRIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_FB_WIDTH:  prdata[COORD_BITS:0]    = fb_width;
      REG_FB_HEIGHT: prdata[COORD_BITS:0]    = fb_height;
      REG_FB_STRIDE: prdata[STRIDE_BITS-1:0] = fb_stride;
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/gbf_addr.sv =====
module gbf_addr
  import gbf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  gbf_adv_t               adv,
  input  logic [COORD_BITS-1:0]  origin_x,
  input  logic [COORD_BITS-1:0]  origin_y,
  input  logic [COORD_BITS-1:0]  rect_width,
  input  logic [COORD_BITS-1:0]  rect_height,
  input  logic [COORD_BITS-1:0]  col,
  input  logic [COORD_BITS-1:0]  row,
  input  logic [COORD_BITS:0]    fb_width,
  input  logic [COORD_BITS:0]    fb_height,
  input  logic [STRIDE_BITS-1:0] fb_stride,
  output logic                   vis2,
  output logic [ADDR_BITS-1:0]   byte_address
);

  localparam int PW = COORD_BITS + 1 + STRIDE_BITS;
  localparam int SW = (PW > ADDR_BITS) ? PW + 1 : ADDR_BITS + 1;

  // Stage 1: absolute coordinates and in-rectangle flags.
  logic [COORD_BITS:0] x1, y1;
  logic                inx1, iny1;
  // Stage 2: clip result and line offset.
  logic [COORD_BITS:0] x2;
  logic [PW-1:0]       line2;
  logic [SW-1:0]       sum;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      x1   <= {1'b0, origin_x} + {1'b0, col};
      y1   <= {1'b0, origin_y} + {1'b0, row};
      inx1 <= col < rect_width;
      iny1 <= row < rect_height;
    end
  end

  // A pixel lies in the clipped span when it is inside the rectangle, its
  // absolute x is below fb_width and its absolute y is below fb_height.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      vis2  <= inx1 && iny1 && (x1 < fb_width) && (y1 < fb_height);
      x2    <= x1;
      line2 <= PW'(y1) * PW'(fb_stride);
    end
  end

  assign sum = SW'(line2) + SW'({x2, 2'b00});

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      byte_address <= vis2 ? sum[ADDR_BITS-1:0] : '0;
    end
  end

endmodule

// ===== rtl/gbf_blend.sv =====
module gbf_blend
  import gbf_pkg::*;
(
  input  logic                clk,
  input  gbf_adv_t            adv,
  input  logic                func,
  input  logic [CH_BITS-1:0]  coverage,
  input  logic [23:0]         fg_rgb,
  input  logic [23:0]         bg_rgb,
  input  logic                vis2,
  output logic [PIX_BITS-1:0] pixel_word
);

  typedef enum logic [1:0] {
    MODE_BG,
    MODE_FG,
    MODE_MIX
  } mode_t;

  mode_t       mode1, mode2;
  logic [23:0] fg1, bg1, fg2, bg2;
  logic [15:0] pf1 [3];
  logic [15:0] pb1 [3];
  logic [15:0] t2  [3];
  logic [15:0] fold [3];
  logic [23:0] mix, rgb;
  logic [CH_BITS-1:0] inv_cov;

  assign inv_cov = COV_FULL - coverage;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      fg1 <= fg_rgb;
      bg1 <= bg_rgb;
      if (func == FUNC_FILL || coverage == COV_NONE) begin
        mode1 <= MODE_BG;
      end else if (coverage == COV_FULL) begin
        mode1 <= MODE_FG;
      end else begin
        mode1 <= MODE_MIX;
      end
      for (int c = 0; c < 3; c++) begin
        pf1[c] <= 16'(fg_rgb[c*8 +: 8]) * 16'(coverage);
        pb1[c] <= 16'(bg_rgb[c*8 +: 8]) * 16'(inv_cov);
      end
    end
  end

  // The weighted sum plus bias stays below 2^16 for all byte inputs.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      fg2   <= fg1;
      bg2   <= bg1;
      mode2 <= mode1;
      for (int c = 0; c < 3; c++) begin
        t2[c] <= pf1[c] + pb1[c] + ROUND_BIAS;
      end
    end
  end

  // Divide by 255 as (t + (t >> 8)) >> 8.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      fold[c]      = t2[c] + (t2[c] >> 8);
      mix[c*8 +: 8] = fold[c][15:8];
    end
    case (mode2)
      MODE_BG:  rgb = bg2;
      MODE_FG:  rgb = fg2;
      MODE_MIX: rgb = mix;
      default:  rgb = bg2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pixel_word <= vis2 ? {ALPHA_OPAQUE, rgb} : '0;
    end
  end

endmodule

// ===== rtl/glyph_blend_fill_pixel_writer.sv =====
// Channel   | Direction | Carries
// ----------+-----------+-------------------------------------------------
// s_axis    | in        | one pixel request of a fill or glyph blend
// m_axis    | out       | write flag, byte address and ARGB32 word
// apb       | in/out    | fb_width, fb_height, fb_stride at 0x0, 0x4, 0x8
//
// One pixel request is taken every clock while m_axis does not stall. Its result
// passes from stage one to stage two and then into the output register. The
// depth is set by the three register stages: clip and channel products, then
// clip compare with line multiply and channel sums, then the divide-by-255 fold
// with the address add.
// Reset is synchronous and clears the valid bits and the configuration
// registers. The data registers are not reset because the valid bits guard them.
// A stall on m_axis holds each stage that has no empty stage ahead of it.
module glyph_blend_fill_pixel_writer
  import gbf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // From bit 0: origin_x, origin_y, rect_width, rect_height, col, row,
  // coverage, fg_rgb, bg_rgb, then zero fill to whole bytes.
  input  logic [((6*COORD_BITS+56+7)/8)*8-1:0] s_tdata,
  // Bit 0: func.
  input  logic        s_tuser,
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // From bit 0: byte_address, pixel_word, then zero fill to 64 bits.
  output logic [63:0] m_tdata,
  // Bit 0: write_enable.
  output logic        m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = COORD_BITS;

  logic [CB:0]            fb_width, fb_height;
  logic [STRIDE_BITS-1:0] fb_stride;

  // Valid bits of the three stages; stage three is the output register.
  logic v1, v2, v3, vis3;
  logic rdy1, rdy2, rdy3;
  gbf_adv_t adv;

  logic                   vis2;
  logic [ADDR_BITS-1:0]   byte_address;
  logic [PIX_BITS-1:0]    pixel_word;

  // A stage may load when it is empty or its content moves on this cycle.
  assign rdy3 = !v3 || m_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign s_tready = rdy1;
  assign adv.s1   = s_tvalid && rdy1;
  assign adv.s2   = v1 && rdy2;
  assign adv.s3   = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      vis3 <= vis2;
    end
  end

  gbf_regs #(.COORD_BITS(CB)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fb_width  (fb_width),
    .fb_height (fb_height),
    .fb_stride (fb_stride)
  );

  gbf_addr #(.COORD_BITS(CB)) u_addr (
    .clk          (clk),
    .adv          (adv),
    .origin_x     (s_tdata[0*CB +: CB]),
    .origin_y     (s_tdata[1*CB +: CB]),
    .rect_width   (s_tdata[2*CB +: CB]),
    .rect_height  (s_tdata[3*CB +: CB]),
    .col          (s_tdata[4*CB +: CB]),
    .row          (s_tdata[5*CB +: CB]),
    .fb_width     (fb_width),
    .fb_height    (fb_height),
    .fb_stride    (fb_stride),
    .vis2         (vis2),
    .byte_address (byte_address)
  );

  gbf_blend u_blend (
    .clk        (clk),
    .adv        (adv),
    .func       (s_tuser),
    .coverage   (s_tdata[6*CB +: CH_BITS]),
    .fg_rgb     (s_tdata[6*CB+8 +: 24]),
    .bg_rgb     (s_tdata[6*CB+32 +: 24]),
    .vis2       (vis2),
    .pixel_word (pixel_word)
  );

  assign m_tvalid = v3;
  assign m_tuser  = vis3;
  assign m_tdata  = {4'b0000, pixel_word, byte_address};

endmodule

// ===== rtl/gbf_checker.sv =====
module gbf_checker
  import gbf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A clipped pixel carries an all-zero payload.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 64'd0)
    else $error("clipped pixel with nonzero payload");

  // A written pixel is opaque.
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[59:52] == ALPHA_OPAQUE)
    else $error("written pixel not opaque");

  // With the output register empty the whole pipeline can take a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind glyph_blend_fill_pixel_writer gbf_checker u_gbf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
